/* rtl/assert_macros.svh */
// Assertion macros of the reverb RTL, used by lfdr_core.
// Uses the enclosing module's clk and active-low rst_n; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever a holds, c holds too.
`define LFDR_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lfdr: same-cycle check failed");

// Next-cycle implication: whenever a holds, c holds in the following cycle.
`define LFDR_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lfdr: next-cycle check failed");

// Condition that must never be seen.
`define LFDR_ASSERT_NEVER(lbl, a) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
        else $error("lfdr: forbidden condition seen");

`endif

/* rtl/lfdr_pkg.sv */
// Shared types and constants of the low-pass feedback delay reverb.
// No dependencies; imported by all reverb modules.
package lfdr_pkg;

    // Delay store geometry
    localparam int ADDR_BITS   = 16;
    localparam int STORE_DEPTH = 1 << ADDR_BITS;

    // Configuration register map
    localparam int CFG_IDX_BITS  = 2;
    localparam int GAIN_BITS     = 17;
    localparam int DELAY_BITS    = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDBACK_GAIN = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INPUT_GAIN    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_LENGTH  = 2'd2;

    localparam logic [GAIN_BITS-1:0]  FEEDBACK_GAIN_RST = 17'd45875;
    localparam logic [GAIN_BITS-1:0]  INPUT_GAIN_RST    = 17'd65536;
    localparam logic [DELAY_BITS-1:0] DELAY_LENGTH_RST  = 16'd4410;

    // Low-pass coefficients, Q16: 0.3 and 0.7
    localparam logic signed [15:0] COEF_B = 16'sd19661;
    localparam logic signed [16:0] COEF_A = 17'sd45875;

    // Q16 rounding offset (one half)
    localparam int ROUND_HALF = 32768;

    typedef struct packed {
        logic [GAIN_BITS-1:0]  feedback_gain;
        logic [GAIN_BITS-1:0]  input_gain;
        logic [DELAY_BITS-1:0] delay_length;
    } cfg_t;

    typedef struct packed {
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic [ADDR_BITS-1:0] wr_addr;
    } mem_ctrl_t;

endpackage

/* rtl/lfdr_cfg_regs.sv */
// Configuration register file of the reverb: gains and delay length.
// Depends on lfdr_pkg for the register map and reset values.
module lfdr_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lfdr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [lfdr_pkg::GAIN_BITS-1:0]       cfg_data,
    output lfdr_pkg::cfg_t                       cfg
);
    import lfdr_pkg::*;

    cfg_t cfg_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register write decode; indexes beyond the map are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.feedback_gain <= FEEDBACK_GAIN_RST;
            cfg_reg.input_gain    <= INPUT_GAIN_RST;
            cfg_reg.delay_length  <= DELAY_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FEEDBACK_GAIN: cfg_reg.feedback_gain <= cfg_data;
                CFG_INPUT_GAIN:    cfg_reg.input_gain    <= cfg_data;
                CFG_DELAY_LENGTH:  cfg_reg.delay_length  <= cfg_data[DELAY_BITS-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

/* rtl/lfdr_delay_mem.sv */
// Delay store: single-port-write, single-port-read synchronous RAM.
// Read data is registered. Depends on lfdr_pkg.
module lfdr_delay_mem #(
    parameter int DATA_BITS = 16
) (
    input  logic                    clk,
    input  lfdr_pkg::mem_ctrl_t     ctrl,
    input  logic [DATA_BITS-1:0]    wdata,
    output logic [DATA_BITS-1:0]    rdata
);
    import lfdr_pkg::*;

    logic [DATA_BITS-1:0] mem [STORE_DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[ctrl.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lfdr_core.sv */
// Sequencer and arithmetic of the reverb: low-pass update, mix, saturation,
// delay store read/write and the output register. Depends on lfdr_pkg and
// assert_macros.svh.
`include "assert_macros.svh"

module lfdr_core #(
    parameter int SB = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lfdr_pkg::cfg_t          cfg,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [SB-1:0]    sample_in,
    input  logic                    block_last,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [SB-1:0]    sample_out,
    output logic                    last_out,
    output lfdr_pkg::mem_ctrl_t     mem_ctrl,
    output logic [SB-1:0]           mem_wdata,
    input  logic [SB-1:0]           mem_rdata
);
    import lfdr_pkg::*;

    // Sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FILT = 2'd1;
    localparam logic [1:0] ST_MIX  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam int FW = SB + 20;    // low-pass accumulator
    localparam int MW = SB + 21;    // output mix accumulator

    logic [1:0]            state_reg, state_next;
    logic [ADDR_BITS-1:0]  wp_reg;
    logic                  wrapped_reg;
    logic                  rd_ok_reg;
    logic signed [SB-1:0]  x_reg;
    logic                  last_reg;
    logic signed [SB-1:0]  held_reg;
    logic signed [SB+1:0]  y_reg;
    logic signed [SB+15:0] pb_reg;
    logic signed [SB+18:0] pa_reg;
    logic signed [SB+17:0] pi_reg;
    logic signed [SB+19:0] pf_reg;
    logic                  out_valid_reg;
    logic signed [SB-1:0]  out_data_reg;
    logic                  out_last_reg;

    logic                  accept;
    logic                  out_free;
    logic                  advance;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic signed [FW-1:0]  acc_f;
    logic signed [SB+3:0]  f_sh;
    logic signed [SB+1:0]  y_sat;
    logic signed [MW-1:0]  acc_m;
    logic signed [SB+4:0]  m_sh;
    logic signed [SB-1:0]  out_sat;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = (state_reg == ST_OUT) && out_free;

    // Read position trails the write position by the delay length
    assign rd_addr = wp_reg - cfg.delay_length;

    // Memory control: read on accept, write when the result is loaded
    always_comb
    begin
        mem_ctrl.rd_en   = accept;
        mem_ctrl.rd_addr = rd_addr;
        mem_ctrl.wr_en   = advance;
        mem_ctrl.wr_addr = wp_reg;
    end
    assign mem_wdata = out_sat;

    // Low-pass: round half up, shift, saturate to SB+2 bits
    assign acc_f = FW'(pb_reg) - FW'(pa_reg) + FW'(ROUND_HALF);
    assign f_sh  = acc_f[FW-1:16];
    assign y_sat = ((&f_sh[SB+3:SB+1]) || !(|f_sh[SB+3:SB+1])) ? f_sh[SB+1:0]
                 : {f_sh[SB+3], {(SB+1){~f_sh[SB+3]}}};

    // Mix: round half up, shift, saturate to SB bits
    assign acc_m   = MW'(pi_reg) + MW'(pf_reg) + MW'(ROUND_HALF);
    assign m_sh    = acc_m[MW-1:16];
    assign out_sat = ((&m_sh[SB+4:SB-1]) || !(|m_sh[SB+4:SB-1])) ? m_sh[SB-1:0]
                   : {m_sh[SB+4], {(SB-1){~m_sh[SB+4]}}};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_FILT;
            ST_FILT: state_next = ST_MIX;
            ST_MIX:  state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state: sequencer, write position, fill tracking, filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            held_reg      <= '0;
            y_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FILT)
            begin
                y_reg    <= y_sat;
                // Entries not yet written since reset read as zero
                held_reg <= rd_ok_reg ? $signed(mem_rdata) : '0;
            end
            if (advance)
            begin
                wp_reg <= wp_reg + 1'b1;
                if (&wp_reg)
                begin
                    wrapped_reg <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg     <= sample_in;
            last_reg  <= block_last;
            rd_ok_reg <= wrapped_reg || (rd_addr < wp_reg);
            pb_reg    <= (SB+16)'(COEF_B) * (SB+16)'(held_reg);
            pa_reg    <= (SB+19)'(COEF_A) * (SB+19)'(y_reg);
        end
        if (state_reg == ST_MIX)
        begin
            pi_reg <= (SB+18)'($signed({1'b0, cfg.input_gain})) * (SB+18)'(x_reg);
            pf_reg <= (SB+20)'($signed({1'b0, cfg.feedback_gain})) * (SB+20)'(y_reg);
        end
        if (advance)
        begin
            out_data_reg <= out_sat;
            out_last_reg <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;
    assign last_out   = out_last_reg;

    // Checks
    `LFDR_ASSERT_NEVER(a_no_rd_wr_overlap, mem_ctrl.rd_en && mem_ctrl.wr_en)
    `LFDR_ASSERT_NXT(a_wp_steps, mem_ctrl.wr_en, wp_reg == $past(wp_reg) + 1'b1)
    `LFDR_ASSERT_IMP(a_result_from_out, $rose(out_valid_reg), $past(state_reg) == ST_OUT)
    `LFDR_ASSERT_NXT(a_wrapped_sticks, wrapped_reg, wrapped_reg)

endmodule

/* rtl/lowpass_feedback_delay_reverb_top.sv */
// Top level of the low-pass feedback delay reverb.
// Depends on lfdr_pkg, lfdr_cfg_regs, lfdr_delay_mem and lfdr_core.
//
// Usage:
//   Input channel (in_valid/in_stall, sample_in, block_last): one signed
//   sample per transfer. Output channel (out_valid/out_stall, sample_out,
//   last_out): one processed sample per input, in order; last_out copies
//   block_last. Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data):
//   index 0 feedback gain, 1 input gain, 2 delay length; write while idle.
//   Sequencing: a new sample is accepted only after the previous one is
//   written back; the sequencer steps through delay store read, low-pass
//   multiply, mix multiply and write back on the single store ports.
//   Reset: gains and delay length return to defaults, filter state and
//   write position clear; the 64K-entry store is not swept, a written-since-
//   reset mark (write position plus wrap flag) makes unwritten entries read
//   as zero, so samples are taken right after reset.
//   Stall: a result held by out_stall stays in the output register; one
//   further sample is accepted and processed, then in_stall stays high
//   until the held result is taken.
module lowpass_feedback_delay_reverb_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic                                block_last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       sample_out,
    output logic                                last_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lfdr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [lfdr_pkg::GAIN_BITS-1:0]      cfg_data
);
    import lfdr_pkg::*;

    cfg_t                   cfg;
    mem_ctrl_t              mem_ctrl;
    logic [SAMPLE_BITS-1:0] mem_wdata;
    logic [SAMPLE_BITS-1:0] mem_rdata;

    // Configuration registers
    lfdr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Delay store
    lfdr_delay_mem #(
        .DATA_BITS (SAMPLE_BITS)
    ) u_mem (
        .clk   (clk),
        .ctrl  (mem_ctrl),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Sequencer and datapath
    lfdr_core #(
        .SB (SAMPLE_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .block_last (block_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .last_out   (last_out),
        .mem_ctrl   (mem_ctrl),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata)
    );

endmodule
